// ===== src/vni_pkg.sv =====
// ----------------------------------------------------------------------------
// Value noise interpolator package
// Shared widths, operation and mode codes, the stage enable bundle and the
// cosine weight ROM, which is built at elaboration.
// ----------------------------------------------------------------------------
package vni_pkg;

    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned W_W      = FRAC_W + 1;
    localparam int unsigned FRAC_ONE = 1 << FRAC_W;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COSINE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd2;

    // Load enables of the first two pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

    typedef logic [FRAC_ONE-1:0][W_W-1:0] cos_rom_t;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Sine in Q30 by a truncated Taylor series, valid for 0 <= x <= pi/2.
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        return sum;
    endfunction

    // Weight S/2*(1 - cos(pi*f/S)), built as S/2 + S/2*sin(pi*(f - S/2)/S).
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t    rom;
        logic [63:0] half;
        logic [63:0] fv;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] base;
        logic [63:0] part;
        logic [63:0] acc;
        half = 64'(FRAC_ONE >> 1);
        base = (half << 30) + (64'd1 << 29);
        for (int unsigned f = 0; f < FRAC_ONE; f++) begin
            fv   = 64'(f);
            d    = (fv >= half) ? fv - half : half - fv;
            s    = sine_q30((d * PI_Q30) >> FRAC_W);
            part = half * s;
            if (fv >= half) begin
                acc = base + part;
            end else begin
                acc = (part > base) ? 64'd0 : base - part;
            end
            rom[f[FRAC_W-1:0]] = W_W'(acc >> 30);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== src/vni_table.sv =====
// ----------------------------------------------------------------------------
// Noise table memory
// One write port and two read ports with registered read data; the read
// registers load only when the first pipeline stage loads.
// ----------------------------------------------------------------------------
module vni_table #(
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic [vni_pkg::VALUE_W-1:0]       wr_data,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr_a,
    input  logic [ADDR_W-1:0]                 rd_addr_b,
    output logic [vni_pkg::VALUE_W-1:0]       rd_data_a,
    output logic [vni_pkg::VALUE_W-1:0]       rd_data_b
);

    logic [vni_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [vni_pkg::VALUE_W-1:0] rd_a_reg;
    logic [vni_pkg::VALUE_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== src/vni_weight.sv =====
// ----------------------------------------------------------------------------
// Interpolation weight unit
// Two registered stages: the fraction and its square, then the weight in
// the shape selected by the mode register (linear, cosine ROM, smoothstep).
// ----------------------------------------------------------------------------
module vni_weight (
    input  logic                            aclk,
    input  vni_pkg::stage_en_t              en,
    input  logic [vni_pkg::FRAC_W-1:0]      fraction,
    input  logic [vni_pkg::MODE_W-1:0]      interp_mode,
    output logic [vni_pkg::W_W-1:0]         weight
);

    localparam int unsigned SQ_W     = 2 * vni_pkg::FRAC_W;
    localparam int unsigned FAC_W    = vni_pkg::FRAC_W + 2;
    localparam int unsigned SMOOTH_W = SQ_W + FAC_W + 1;
    localparam int unsigned HALF_SQ  = (vni_pkg::FRAC_ONE * vni_pkg::FRAC_ONE) / 2;

    logic [vni_pkg::FRAC_W-1:0] frac_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [SQ_W-1:0]            sq_next;
    logic [FAC_W-1:0]           factor;
    logic [SMOOTH_W-1:0]        smooth_acc;
    logic [vni_pkg::W_W-1:0]    smooth_w;
    logic [vni_pkg::W_W-1:0]    w_reg;
    logic [vni_pkg::W_W-1:0]    w_next;

    assign sq_next = SQ_W'(fraction) * SQ_W'(fraction);

    // Smoothstep f*f*(3 - 2f), rounded half up.
    assign factor     = FAC_W'(3 * vni_pkg::FRAC_ONE) - FAC_W'({frac_reg, 1'b0});
    assign smooth_acc = SMOOTH_W'(sq_reg) * SMOOTH_W'(factor) + SMOOTH_W'(HALF_SQ);
    assign smooth_w   = smooth_acc[SQ_W +: vni_pkg::W_W];

    always_comb begin
        unique case (interp_mode)
            vni_pkg::MODE_COSINE: begin
                w_next = vni_pkg::COS_ROM[frac_reg];
            end
            vni_pkg::MODE_SMOOTH: begin
                w_next = smooth_w;
            end
            default: begin
                w_next = {1'b0, frac_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            frac_reg <= fraction;
            sq_reg   <= sq_next;
        end
        if (en.s2) begin
            w_reg <= w_next;
        end
    end

    assign weight = w_reg;

endmodule

// ===== src/value_noise_interpolator.sv =====
// ----------------------------------------------------------------------------
// One-dimensional value noise interpolator
// A table of signed Q8.8 noise values, loaded by write items and sampled
// between neighbouring entries with a linear, cosine or smoothstep weight.
// ----------------------------------------------------------------------------
// Usage: an item on the s_ channel either writes s_write_value into the
// table entry s_index (s_opcode clear) or samples the table at position
// s_index + s_fraction/256 (s_opcode set). A write item produces no result;
// a sample item produces exactly one item on the m_ channel, in order.
// The weight shape comes from interp_mode, written through cfg_wr_en and
// cfg_wr_data while the block is idle.
// Pipeline: a sample's result passes the table read, weight and difference,
// multiply and sum registers in turn before it is presented on m_valid.
// Throughput: one item per cycle unless the receiver stalls, set by the single
// pipeline and two table read ports that fetch both neighbours at once.
// A write is applied at its acceptance edge, so a sample in the very next
// cycle already sees the new value.
// Reset clears the pipeline valid bits and sets interp_mode to linear; the
// table keeps whatever it held and must be written before it is sampled.
// When the receiver stalls, results collapse into empty stages first and
// s_ready falls only once every stage holds a pending result.
// ----------------------------------------------------------------------------
module value_noise_interpolator #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [vni_pkg::MODE_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [vni_pkg::INDEX_W-1:0]          s_index,
    input  logic [vni_pkg::FRAC_W-1:0]           s_fraction,
    input  logic signed [vni_pkg::VALUE_W-1:0]   s_write_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vni_pkg::VALUE_W-1:0]   m_sample_value
);

    localparam int unsigned ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int unsigned IDX_COUNT = 1 << vni_pkg::INDEX_W;
    localparam int unsigned DIFF_W    = vni_pkg::VALUE_W + 1;
    localparam int unsigned PROD_W    = DIFF_W + vni_pkg::W_W + 1;
    localparam int unsigned SUM_W     = PROD_W - vni_pkg::FRAC_W;

    typedef logic [IDX_COUNT-1:0][ADDR_W-1:0] wrap_table_t;

    // Index modulo the table depth for every possible index, built by
    // counting so that no divider is needed.
    function automatic wrap_table_t build_wrap_table();
        wrap_table_t t;
        int unsigned r;
        r = 0;
        for (int unsigned i = 0; i < IDX_COUNT; i++) begin
            t[i[vni_pkg::INDEX_W-1:0]] = ADDR_W'(r);
            r++;
            if (r == TABLE_DEPTH) begin
                r = 0;
            end
        end
        return t;
    endfunction

    localparam wrap_table_t WRAP_TABLE = build_wrap_table();

    // Mode register.
    logic [vni_pkg::MODE_W-1:0] interp_mode_reg;

    // Handshake and stage control.
    logic s_accept;
    logic is_sample;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic out_ready;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic m_valid_reg;
    vni_pkg::stage_en_t stage_en;

    // Table addressing.
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [vni_pkg::VALUE_W-1:0] rd_a;
    logic [vni_pkg::VALUE_W-1:0] rd_b;

    // Datapath.
    logic [vni_pkg::W_W-1:0]          weight;
    logic signed [vni_pkg::VALUE_W-1:0] a2_reg;
    logic signed [vni_pkg::VALUE_W-1:0] a3_reg;
    logic signed [DIFF_W-1:0]         diff_reg;
    logic signed [DIFF_W-1:0]         diff_next;
    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [PROD_W-1:0]         prod_next;
    logic signed [SUM_W-1:0]          prod_shift;
    logic signed [SUM_W-1:0]          a_ext;
    logic signed [SUM_W-1:0]          sum_next;
    logic signed [vni_pkg::VALUE_W-1:0] m_sample_value_reg;

    assign s_accept  = s_valid && s_ready;
    assign is_sample = (s_opcode == vni_pkg::OP_SAMPLE);

    // Each stage may load when it is empty or when the stage after it
    // moves on, so bubbles are squeezed out behind a stalled output.
    assign out_ready = !m_valid_reg || m_ready;
    assign s3_ready  = !v3_reg || out_ready;
    assign s2_ready  = !v2_reg || s3_ready;
    assign s1_ready  = !v1_reg || s2_ready;
    assign s_ready   = s1_ready;

    assign stage_en.s1 = s1_ready;
    assign stage_en.s2 = s2_ready;

    // The entry after the last one is entry zero.
    assign addr_a = WRAP_TABLE[s_index];
    assign addr_b = (addr_a == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : addr_a + ADDR_W'(1);

    vni_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (s_accept && !is_sample),
        .wr_addr   (addr_a),
        .wr_data   (s_write_value),
        .rd_en     (s1_ready),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    vni_weight u_weight (
        .aclk        (aclk),
        .en          (stage_en),
        .fraction    (s_fraction),
        .interp_mode (interp_mode_reg),
        .weight      (weight)
    );

    // a*(S-w) + b*w over S equals a + (b-a)*w over S, since a*S divides
    // exactly; the arithmetic shift then gives the floor.
    assign diff_next  = $signed({rd_b[vni_pkg::VALUE_W-1], rd_b})
                      - $signed({rd_a[vni_pkg::VALUE_W-1], rd_a});
    assign prod_next  = diff_reg * $signed({1'b0, weight});
    assign prod_shift = prod_reg[PROD_W-1:vni_pkg::FRAC_W];
    assign a_ext      = SUM_W'(a3_reg);
    assign sum_next   = a_ext + prod_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interp_mode_reg <= vni_pkg::MODE_LINEAR;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                interp_mode_reg <= cfg_wr_data;
            end
            if (s1_ready) begin
                v1_reg <= s_accept && is_sample;
            end
            if (s2_ready) begin
                v2_reg <= v1_reg;
            end
            if (s3_ready) begin
                v3_reg <= v2_reg;
            end
            if (out_ready) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            a2_reg   <= $signed(rd_a);
            diff_reg <= diff_next;
        end
        if (s3_ready) begin
            a3_reg   <= a2_reg;
            prod_reg <= prod_next;
        end
        if (out_ready) begin
            m_sample_value_reg <= sum_next[vni_pkg::VALUE_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_sample_value_reg;

`ifndef ASSERT_OFF
    // The input side stalls only when every stage holds a pending result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && m_valid_reg))
        else $error("input stalled while a pipeline stage was empty");

    // A sample item always enters the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_sample) |=> v1_reg)
        else $error("accepted sample item was lost");

    // A write item never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !is_sample) |=> !v1_reg)
        else $error("write item entered the result pipeline");

    // The weight never exceeds one whole unit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (weight <= vni_pkg::W_W'(vni_pkg::FRAC_ONE)))
        else $error("interpolation weight out of range");

    // A finished result moves into the output register when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && out_ready) |=> m_valid_reg)
        else $error("result dropped on its way to the output");
`endif

endmodule
